>>> rtl/cbhd_pkg.sv
// ============================================================================
// cbhd_pkg
// Shared types and constants of the button click and hold detector.
// ============================================================================
package cbhd_pkg;

  // The number of buttons is fixed by the 4-bit level field and the 2-bit
  // button index of the result.
  localparam int unsigned BUTTONS = 4;
  localparam int unsigned BTN_W   = 2;
  localparam int unsigned ADDR_W  = 4;

  localparam logic [BTN_W-1:0] LAST_BTN = BTN_W'(BUTTONS - 1);

  // Register indexes on the configuration port (byte address divided by 4).
  localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [1:0] REG_CLICK_TICKS = 2'd1;
  localparam logic [1:0] REG_HOLD_TICKS  = 2'd2;

  localparam logic [31:0] TICK_PERIOD_RST = 32'd50;
  localparam logic [7:0]  CLICK_TICKS_RST = 8'd1;
  localparam logic [7:0]  HOLD_TICKS_RST  = 8'd20;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_HOLD  = 2'd2
  } event_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the poll, evaluate the debounce tick
    logic step;     // evaluate one button and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
    logic last_btn;  // the current button is the highest-numbered one
  } status_t;

endpackage

>>> rtl/cbhd_poll_if.sv
// ============================================================================
// cbhd_poll_if
// Valid/ready channel that carries one poll of the raw button levels.
// ============================================================================
interface cbhd_poll_if;
  logic                         valid;
  logic                         ready;
  logic [cbhd_pkg::BUTTONS-1:0] raw_levels;
  logic [31:0]                  timestamp;

  modport source (output valid, output raw_levels, output timestamp, input ready);
  modport sink   (input valid, input raw_levels, input timestamp, output ready);
endinterface

>>> rtl/cbhd_evt_if.sv
// ============================================================================
// cbhd_evt_if
// Valid/ready channel that carries one per-button event result.
// ============================================================================
interface cbhd_evt_if;
  logic                       valid;
  logic                       ready;
  logic [cbhd_pkg::BTN_W-1:0] button;
  logic [1:0]                 event_res;
  logic                       last;

  modport source (output valid, output button, output event_res, output last, input ready);
  modport sink   (input valid, input button, input event_res, input last, output ready);
endinterface

>>> rtl/cbhd_cfg.sv
// ============================================================================
// cbhd_cfg
// APB register file holding the tick period and the click and hold limits.
// ============================================================================
module cbhd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbhd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [31:0]                 tick_period,
  output logic [7:0]                  click_ticks,
  output logic [7:0]                  hold_ticks
);
  import cbhd_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_PERIOD_RST;
      click_ticks <= CLICK_TICKS_RST;
      hold_ticks  <= HOLD_TICKS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TICK_PERIOD: tick_period <= pwdata;
        REG_CLICK_TICKS: click_ticks <= pwdata[7:0];
        REG_HOLD_TICKS:  hold_ticks  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TICK_PERIOD: prdata = tick_period;
      REG_CLICK_TICKS: prdata = {24'd0, click_ticks};
      REG_HOLD_TICKS:  prdata = {24'd0, hold_ticks};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/cbhd_ctrl.sv
// ============================================================================
// cbhd_ctrl
// Controller: takes a poll, then walks the buttons one per result slot.
// ============================================================================
module cbhd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              poll_valid,
  output logic              poll_ready,
  input  cbhd_pkg::status_t status,
  output cbhd_pkg::cmd_t    cmd
);
  import cbhd_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (poll_valid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.out_free && status.last_btn) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    poll_ready  = 1'b0;
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    case (state)
      ST_IDLE: begin
        poll_ready  = 1'b1;
        cmd.capture = poll_valid;
      end
      ST_RUN: begin
        cmd.step = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/cbhd_dp.sv
// ============================================================================
// cbhd_dp
// Datapath: tick timer, per-button counters and levels, result register.
// ============================================================================
module cbhd_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  cbhd_pkg::cmd_t               cmd,
  output cbhd_pkg::status_t            status,
  input  logic [cbhd_pkg::BUTTONS-1:0] raw_levels,
  input  logic [31:0]                  timestamp,
  input  logic [31:0]                  tick_period,
  input  logic [7:0]                   click_ticks,
  input  logic [7:0]                   hold_ticks,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cbhd_pkg::BTN_W-1:0]   button,
  output logic [1:0]                   event_res,
  output logic                         last
);
  import cbhd_pkg::*;

  logic [31:0]        last_tick_time;
  logic               tick;
  logic [BUTTONS-1:0] levels;
  logic [BUTTONS-1:0] prev_level;
  logic [7:0]         press_count [BUTTONS];
  logic [BTN_W-1:0]   idx;

  logic [31:0] elapsed;
  logic        tick_now;
  logic        lvl;
  logic        prv;
  logic [7:0]  cnt;
  logic [7:0]  cnt_inc;
  logic [7:0]  cnt_next;
  event_t      ev;

  // Wrapped difference; the subtraction is modulo 2^32 by width.
  assign elapsed  = timestamp - last_tick_time;
  assign tick_now = elapsed > tick_period;

  assign status.out_free = !out_valid || out_ready;
  assign status.last_btn = (idx == LAST_BTN);

  always_comb begin
    lvl     = levels[idx];
    prv     = prev_level[idx];
    cnt     = press_count[idx];
    cnt_inc = (tick && (cnt < hold_ticks)) ? cnt + 8'd1 : cnt;
    ev      = EV_NONE;
    if (!prv && lvl) begin
      cnt_next = 8'd0;
    end else if (prv && lvl) begin
      cnt_next = cnt_inc;
      if (cnt_inc == hold_ticks) begin
        ev = EV_HOLD;
        // Park above the threshold so hold fires once; a threshold of 255
        // saturates and keeps reporting hold.
        cnt_next = (hold_ticks == 8'hFF) ? 8'hFF : hold_ticks + 8'd1;
      end
    end else begin
      if ((cnt_inc > click_ticks) && (cnt_inc < hold_ticks)) ev = EV_CLICK;
      cnt_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick_time <= 32'd0;
      prev_level     <= '0;
      for (int i = 0; i < BUTTONS; i++) press_count[i] <= 8'd0;
      idx            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx <= '0;
        if (tick_now) last_tick_time <= timestamp;
      end
      if (cmd.step) begin
        press_count[idx] <= cnt_next;
        prev_level[idx]  <= lvl;
        idx              <= idx + BTN_W'(1);
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      levels <= raw_levels;
      tick   <= tick_now;
    end
    if (cmd.step) begin
      button    <= idx;
      event_res <= ev;
      last      <= (idx == LAST_BTN);
    end
  end

endmodule

>>> rtl/button_click_hold_detector.sv
// ============================================================================
// button_click_hold_detector
// Debounced click and long-press detector for four buttons, one poll in.
// ============================================================================
// A poll is captured in the idle state; the controller then evaluates one
// button per cycle while the result register is free. A new poll is taken
// only after the last button's result is loaded: one capture step plus one
// step per button through the shared counter update. Reset (rst,
// synchronous) restores the register defaults and clears the tick time, the
// button levels and the counters.
module button_click_hold_detector (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbhd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  cbhd_poll_if.sink                   poll,
  cbhd_evt_if.source                  evt
);
  import cbhd_pkg::*;

  logic [31:0] tick_period;
  logic [7:0]  click_ticks;
  logic [7:0]  hold_ticks;
  cmd_t        cmd;
  status_t     status;

  cbhd_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tick_period (tick_period),
    .click_ticks (click_ticks),
    .hold_ticks  (hold_ticks)
  );

  cbhd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .poll_valid (poll.valid),
    .poll_ready (poll.ready),
    .status     (status),
    .cmd        (cmd)
  );

  cbhd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .raw_levels  (poll.raw_levels),
    .timestamp   (poll.timestamp),
    .tick_period (tick_period),
    .click_ticks (click_ticks),
    .hold_ticks  (hold_ticks),
    .out_valid   (evt.valid),
    .out_ready   (evt.ready),
    .button      (evt.button),
    .event_res   (evt.event_res),
    .last        (evt.last)
  );

endmodule
